[rtl/fcc_pkg.sv]
// Shared types and constants for the FAT16 cluster chain engine.
package fcc_pkg;

	// Command codes carried in the mode field
	localparam logic [2:0] MODE_READ   = 3'd0;
	localparam logic [2:0] MODE_WRITE  = 3'd1;
	localparam logic [2:0] MODE_FREE   = 3'd2;
	localparam logic [2:0] MODE_FOLLOW = 3'd3;
	localparam logic [2:0] MODE_FIND   = 3'd4;
	localparam logic [2:0] MODE_COUNT  = 3'd5;

	// Result status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NOFREE = 2'd1;
	localparam logic [1:0] STATUS_LIMIT  = 2'd2;
	localparam logic [1:0] STATUS_RANGE  = 2'd3;

	// Configuration register indexes
	localparam int          CFG_IDX_W          = 2;
	localparam logic [1:0]  CFG_ENTRIES_IN_USE = 2'd0;
	localparam logic [1:0]  CFG_END_MARKER     = 2'd1;
	localparam logic [12:0] ENTRIES_RESET      = 13'd4096;
	localparam logic [15:0] END_MARKER_RESET   = 16'd65528;

	// Free walk stops at FREE_END and above; free search starts at FIND_START
	localparam logic [15:0] FREE_END   = 16'hFFF8;
	localparam logic [15:0] FREE_ENTRY = 16'h0000;
	localparam logic [15:0] FIND_START = 16'd2;

	typedef struct packed {
		logic [15:0] link_offset;
		logic [15:0] link_value;
		logic [15:0] cluster;
		logic [2:0]  mode;
	} fcc_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] result;
	} fcc_res_t;

endpackage

[rtl/fcc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module fcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/fcc_walker.sv]
// Command sequencer: clears the table, then runs one command at a time over it.
module fcc_walker #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [12:0]      entries_in_use,
	input  logic [15:0]      end_marker,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  fcc_pkg::fcc_cmd_t cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output fcc_pkg::fcc_res_t res
);

	import fcc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [16:0]   DEPTH17 = 17'(TABLE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_WALK  = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [2:0]    mode_q;
	logic [15:0]   cur_q, cur_d;
	logic [15:0]   val_q;
	logic [15:0]   offs_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          fwd_s1;
	logic [15:0]   fwd_data_s1;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [15:0]   wr_data, rd_data, data;
	logic [16:0]   lim;
	logic [CW-1:0] cnt_inc;
	logic [15:0]   cnt_sat;

	function automatic logic in_tab(input logic [15:0] v);
		return {1'b0, v} < DEPTH17;
	endfunction

	fcc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Entry written in the cycle its read was issued comes from the forward path
	assign data = fwd_s1 ? fwd_data_s1 : rd_data;

	assign lim = ({4'd0, entries_in_use} > DEPTH17) ? DEPTH17 : {4'd0, entries_in_use};
	assign cnt_inc = CW'(cnt_q + 1'b1);
	assign cnt_sat = (17'(cnt_q) > 17'h0FFFF) ? 16'hFFFF : 16'(cnt_q);
	assign cmd_ready = (state_q == S_IDLE);

	// Next-step logic
	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		cnt_d     = cnt_q;
		rd_en     = 1'b0;
		rd_addr   = cur_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = cur_q[AW-1:0];
		wr_data   = FREE_ENTRY;
		res_valid = 1'b0;
		res       = '{status: STATUS_OK, result: 16'd0};

		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EXEC;
					cnt_d   = '0;
					cur_d   = cmd.cluster;
				end
			end
			S_EXEC: begin
				res_valid = 1'b1;
				case (mode_q)
					MODE_READ: begin
						if (!in_tab(cur_q)) begin
							res.status = STATUS_RANGE;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
						end
					end
					MODE_WRITE: begin
						if (!in_tab(cur_q)) begin
							res.status = STATUS_RANGE;
						end else begin
							wr_en   = 1'b1;
							wr_data = val_q;
						end
					end
					MODE_FREE: begin
						if (cur_q == FREE_ENTRY || cur_q >= FREE_END) begin
							res.status = STATUS_OK;
						end else if (!in_tab(cur_q)) begin
							res.status = STATUS_RANGE;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
							cnt_d     = CW'(1);
						end
					end
					MODE_FOLLOW: begin
						res.result = cur_q;
						if (offs_q == 16'd0) begin
							res.status = STATUS_OK;
						end else if (!in_tab(cur_q)) begin
							res.status = STATUS_RANGE;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
						end
					end
					MODE_FIND: begin
						if ({1'b0, FIND_START} >= lim) begin
							res.status = STATUS_NOFREE;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
							rd_addr   = FIND_START[AW-1:0];
							cur_d     = FIND_START;
						end
					end
					MODE_COUNT: begin
						if (cur_q >= end_marker) begin
							res.status = STATUS_OK;
						end else if (!in_tab(cur_q)) begin
							res.status = STATUS_RANGE;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
							cnt_d     = CW'(1);
						end
					end
					default: ;
				endcase
				if (rd_en) begin
					state_d = S_WALK;
				end else if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				res_valid = 1'b1;
				case (mode_q)
					MODE_READ: begin
						res.result = data;
					end
					MODE_FREE: begin
						// Visited entry goes back to free
						wr_en = 1'b1;
						if (data == FREE_ENTRY || data >= FREE_END) begin
							res.status = STATUS_OK;
						end else if (!in_tab(data)) begin
							res.status = STATUS_RANGE;
						end else if (cnt_q >= DEPTH_C) begin
							res.status = STATUS_LIMIT;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
							rd_addr   = data[AW-1:0];
							cur_d     = data;
							cnt_d     = cnt_inc;
						end
					end
					MODE_FOLLOW: begin
						res.result = data;
						if (data >= end_marker || 17'(cnt_inc) >= {1'b0, offs_q}) begin
							res.status = STATUS_OK;
						end else if (cnt_inc >= DEPTH_C) begin
							res.status = STATUS_LIMIT;
						end else if (!in_tab(data)) begin
							res.status = STATUS_RANGE;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
							rd_addr   = data[AW-1:0];
							cur_d     = data;
							cnt_d     = cnt_inc;
						end
					end
					MODE_FIND: begin
						if (data == FREE_ENTRY) begin
							res.result = cur_q;
						end else if (({1'b0, cur_q} + 17'd1) >= lim) begin
							res.status = STATUS_NOFREE;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
							cur_d     = cur_q + 16'd1;
							rd_addr   = cur_d[AW-1:0];
						end
					end
					MODE_COUNT: begin
						if (data >= end_marker) begin
							res.result = cnt_sat;
						end else if (!in_tab(data)) begin
							res.status = STATUS_RANGE;
						end else if (cnt_q >= DEPTH_C) begin
							res.status = STATUS_LIMIT;
						end else begin
							res_valid = 1'b0;
							rd_en     = 1'b1;
							rd_addr   = data[AW-1:0];
							cur_d     = data;
							cnt_d     = cnt_inc;
						end
					end
					default: ;
				endcase
				if (!rd_en && res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
		end
	end

	// Command and walk registers
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		cnt_q <= cnt_d;
		if (state_q == S_IDLE && cmd_valid) begin
			mode_q <= cmd.mode;
			val_q  <= cmd.link_value;
			offs_q <= cmd.link_offset;
		end
		if (rd_en) begin
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

endmodule

[rtl/fat16_cluster_chain_engine.sv]
// FAT16 cluster chain engine: config registers, stream ports and result register.
//
// After reset the block clears its TABLE_DEPTH-entry table one entry per cycle
// (4096 entries by default) and accepts no word until that is done; config
// writes are taken at any time. Commands run one at a time through a single
// table RAM with registered read data: a write or a command that ends without
// a table access gives its result from the execute state, while a read, chain
// walk, follow or free search issues its first read there and then walks the
// table in the walk state. A finished result waits in an output register; it
// stalls the engine only when the previous result has not been taken yet.
module fat16_cluster_chain_engine #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [2:0]                       s_tuser,  // mode[2:0]
	input  logic [47:0]                      s_tdata,  // cluster[15:0], link_value[31:16],
	                                                   // link_offset[47:32]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,  // result[15:0]
	output logic [1:0]                       m_tuser,  // status[1:0]
	// config write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                      cfg_data
);

	import fcc_pkg::*;

	logic [12:0] entries_q;
	logic [15:0] end_marker_q;
	fcc_cmd_t    cmd;
	fcc_res_t    res, res_q;
	logic        res_valid, res_ready;
	logic        m_tvalid_q;

	assign cfg_ready = 1'b1;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q    <= ENTRIES_RESET;
			end_marker_q <= END_MARKER_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENTRIES_IN_USE: entries_q    <= cfg_data[12:0];
				CFG_END_MARKER:     end_marker_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input word unpack: mode sits in the low bits of the command
	assign cmd = {s_tdata, s_tuser};

	fcc_walker #(.TABLE_DEPTH(TABLE_DEPTH)) u_walker (
		.clk            (clk),
		.arst_n         (arst_n),
		.entries_in_use (entries_q),
		.end_marker     (end_marker_q),
		.cmd_valid      (s_tvalid),
		.cmd_ready      (s_tready),
		.cmd            (cmd),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

	// Result register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q.result;
	assign m_tuser  = res_q.status;

	// One command in flight: accepting a word drops ready next cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while one is in flight");

	// A result is never pushed over one that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && m_tvalid_q && !m_tready |=> $stable(res_q))
		else $error("pending result overwritten");

	// No-free status always reports index zero
	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && res_q.status == STATUS_NOFREE |-> res_q.result == 16'd0)
		else $error("no-free result carries an index");

endmodule
